>>> design/cas3b_pkg.sv
// Shared types, constants and tables for the three-beacon position core.
package cas3b_pkg;

    localparam int ANGLE_W     = 20;
    localparam int DIFF_W      = 21;
    localparam int MAG_W       = 20;
    localparam int COORD_W     = 16;
    localparam int LIM_W       = 15;
    localparam int QN_W        = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF    = 18;

    localparam longint PI_Q30      = 64'd3373259426;
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B1X     = 3'd0,
        REG_B1Y     = 3'd1,
        REG_B2X     = 3'd2,
        REG_B2Y     = 3'd3,
        REG_B3X     = 3'd4,
        REG_B3Y     = 3'd5,
        REG_COT_LIM = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] bearing_one;
        logic signed [ANGLE_W-1:0] bearing_two;
        logic signed [ANGLE_W-1:0] bearing_three;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [QN_W-1:0]    quality_n;
        logic                      degenerate;
    } t_out;

    // angle differences split into sign and magnitude
    typedef struct packed {
        logic             sign_a;
        logic [MAG_W-1:0] mag_a;
        logic             sign_b;
        logic [MAG_W-1:0] mag_b;
    } t_cls;

    typedef struct packed {
        logic signed [COORD_W-1:0] b1x;
        logic signed [COORD_W-1:0] b1y;
        logic signed [COORD_W-1:0] b2x;
        logic signed [COORD_W-1:0] b2y;
        logic signed [COORD_W-1:0] b3x;
        logic signed [COORD_W-1:0] b3y;
        logic [LIM_W-1:0]          cot_limit;
    } t_cfg;

    // atan(2^-i) in Q2.30
    function automatic logic [30:0] atan_q30(input int i);
        logic [30:0] v;
        case (i)
            0:       v = 31'd843314857;
            1:       v = 31'd497837829;
            2:       v = 31'd263043837;
            3:       v = 31'd133525159;
            4:       v = 31'd67021687;
            5:       v = 31'd33543516;
            6:       v = 31'd16775851;
            7:       v = 31'd8388437;
            8:       v = 31'd4194283;
            9:       v = 31'd2097149;
            default: v = (i <= 30) ? (31'd1 << (30 - i)) : 31'd0;
        endcase
        return v;
    endfunction

endpackage

>>> design/cas3b_front.sv
// Front stage: takes bearing requests and forms the two angle differences.
module cas3b_front
    import cas3b_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    input  logic i_q_full,
    output logic o_push,
    output t_cls o_cls
);

    logic              r_valid;
    t_cls              r_cls;
    logic signed [DIFF_W-1:0] da;
    logic signed [DIFF_W-1:0] db;

    assign da = DIFF_W'(i_data.bearing_one) - DIFF_W'(i_data.bearing_three);
    assign db = DIFF_W'(i_data.bearing_three) - DIFF_W'(i_data.bearing_two);

    assign o_ready = !r_valid || !i_q_full;
    assign o_push  = r_valid && !i_q_full;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cls.sign_a <= da[DIFF_W-1];
            r_cls.mag_a  <= MAG_W'(da[DIFF_W-1] ? -da : da);
            r_cls.sign_b <= db[DIFF_W-1];
            r_cls.mag_b  <= MAG_W'(db[DIFF_W-1] ? -db : db);
        end
    end

endmodule

>>> design/cas3b_queue.sv
// Short queue between the front stage and the arithmetic pipeline.
module cas3b_queue
    import cas3b_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cls o_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cls             r_mem [0:QUEUE_DEPTH-1];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> design/cas3b_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cas3b_div #(
    parameter int NW = 50,
    parameter int DW = 34,
    parameter int QW = 31
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    // caller keeps i_num below i_den * 2^QW
    logic [DW-1:0] r_rem [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_low [0:QW-1];
    logic [QW-1:0] r_quo [0:QW-1];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW-1:0] cur_rem;
        logic [DW-1:0] cur_den;
        logic [QW-1:0] cur_low;
        logic [QW-1:0] cur_quo;
        logic [DW:0]   rr;
        logic [DW:0]   diff;
        logic          ge;

        if (s == 0) begin : g_first
            assign cur_rem = DW'(i_num >> QW);
            assign cur_den = i_den;
            assign cur_low = i_num[QW-1:0];
            assign cur_quo = '0;
        end else begin : g_next
            assign cur_rem = r_rem[s-1];
            assign cur_den = r_den[s-1];
            assign cur_low = r_low[s-1];
            assign cur_quo = r_quo[s-1];
        end

        assign rr   = {cur_rem, cur_low[QW-1]};
        assign diff = rr - {1'b0, cur_den};
        assign ge   = (rr >= {1'b0, cur_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? diff[DW-1:0] : rr[DW-1:0];
                r_den[s] <= cur_den;
                r_low[s] <= cur_low << 1;
                r_quo[s] <= {cur_quo[QW-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

>>> design/cas3b_dly.sv
// Enabled delay line for values that ride alongside a divider.
module cas3b_dly #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [0:D-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_q = r_pipe[D-1];

endmodule

>>> design/cas3b_back.sv
// Arithmetic pipeline: angle reduction, CORDIC, cotangents, slope, N and position.
module cas3b_back
    import cas3b_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  t_cls i_cls,
    output logic o_take,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int MW    = MAG_W + SHIFT;
    localparam int QB    = (MW > 32) ? MW - 31 : 1;
    localparam int WW    = ((MW > 32) ? MW : 32) + 1;
    localparam int CW    = 34;
    localparam int CQ    = 31;
    localparam int CNW   = CW + 16;
    localparam int HW    = 36;
    localparam int SNW   = HW + 16;
    localparam int PNW   = 69;
    localparam int PQ    = 17;
    localparam int LAT   = QB + CORDIC_STEPS + 92;
    localparam int SB_W  = 4 + 2 * HW;
    localparam int PB_W  = 5 + QN_W;

    localparam logic signed [CW-1:0] PI_C   = CW'(PI_Q30);
    localparam logic signed [CW-1:0] HALF_C = CW'(HALF_PI_Q30);
    localparam logic signed [CW-1:0] X0     = CW'(2**30);

    function automatic logic signed [31:0] sat_q(input logic ovf, input logic neg,
                                                 input logic [30:0] q);
        logic signed [31:0] v;
        if (ovf) begin
            v = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
        return v;
    endfunction

    function automatic logic signed [15:0] pos_calc(input logic ovf, input logic neg,
                                                    input logic [PQ-1:0] q,
                                                    input logic signed [15:0] base);
        logic [PQ:0]        q18;
        logic signed [PQ+1:0] sq;
        logic signed [PQ+2:0] t;
        logic signed [15:0]  v;
        q18 = ovf ? (PQ+1)'(1) << PQ : {1'b0, q};
        sq  = neg ? -$signed({1'b0, q18}) : $signed({1'b0, q18});
        t   = (PQ+3)'(base) + (PQ+3)'(sq);
        if (t > (PQ+3)'(32767)) begin
            v = 16'sh7FFF;
        end else if (t < -(PQ+3)'(32768)) begin
            v = 16'sh8000;
        end else begin
            v = 16'(t);
        end
        return v;
    endfunction

    logic            en;
    logic [LAT-1:0]  r_vld;

    // whole pipeline moves together; stalls only when the output is held
    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_take  = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ---------------- cotangent lanes ----------------
    logic                 lane_sgn [0:1];
    logic [MAG_W-1:0]     lane_mag [0:1];
    logic signed [31:0]   r_cot    [0:1];

    assign lane_sgn[0] = i_cls.sign_a;
    assign lane_mag[0] = i_cls.mag_a;
    assign lane_sgn[1] = i_cls.sign_b;
    assign lane_mag[1] = i_cls.mag_b;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [WW-1:0]        r_rem [0:QB-1];
        logic                 r_sgn [0:QB-1];
        logic signed [CW-1:0] r_za;
        logic signed [CW-1:0] r_x [0:CORDIC_STEPS-1];
        logic signed [CW-1:0] r_y [0:CORDIC_STEPS-1];
        logic signed [CW-1:0] r_z [0:CORDIC_STEPS-1];
        logic signed [CW-1:0] rm;
        logic signed [CW-1:0] z0;
        logic signed [CW-1:0] fx;
        logic signed [CW-1:0] fy;
        logic [CW-1:0]        ux;
        logic [CW-1:0]        uy;
        logic [CNW-1:0]       r_pn;
        logic [CW-1:0]        r_pd;
        logic [3:0]           r_pf;
        logic [3:0]           pf_d;
        logic [CQ-1:0]        quo;
        logic signed [32:0]   lim;
        logic signed [32:0]   cv;

        // remainder modulo pi, one restoring step per stage
        for (genvar s = 0; s < QB; s++) begin : g_red
            localparam logic [WW-1:0] SUB = WW'(PI_Q30) << (QB - 1 - s);
            logic [WW-1:0] cur;
            logic          cs;
            if (s == 0) begin : g_first
                assign cur = WW'(lane_mag[l]) << SHIFT;
                assign cs  = lane_sgn[l];
            end else begin : g_next
                assign cur = r_rem[s-1];
                assign cs  = r_sgn[s-1];
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[s] <= (cur >= SUB) ? cur - SUB : cur;
                    r_sgn[s] <= cs;
                end
            end
        end

        // fold into [-pi/2, pi/2)
        assign rm = $signed(CW'(r_rem[QB-1][31:0]));
        assign z0 = r_sgn[QB-1] ? -rm : rm;

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (z0 >= HALF_C) begin
                    r_za <= z0 - PI_C;
                end else if (z0 < -HALF_C) begin
                    r_za <= z0 + PI_C;
                end else begin
                    r_za <= z0;
                end
            end
        end

        for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
            localparam logic signed [CW-1:0] AT = CW'(atan_q30(s));
            logic signed [CW-1:0] cx;
            logic signed [CW-1:0] cy;
            logic signed [CW-1:0] cz;
            logic                 dir;
            if (s == 0) begin : g_first
                assign cx = X0;
                assign cy = '0;
                assign cz = r_za;
            end else begin : g_next
                assign cx = r_x[s-1];
                assign cy = r_y[s-1];
                assign cz = r_z[s-1];
            end
            assign dir = !cz[CW-1];
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_x[s] <= dir ? cx - (cy >>> s) : cx + (cy >>> s);
                    r_y[s] <= dir ? cy + (cx >>> s) : cy - (cx >>> s);
                    r_z[s] <= dir ? cz - AT : cz + AT;
                end
            end
        end

        // cot = x / y in Q16.16
        assign fx = r_x[CORDIC_STEPS-1];
        assign fy = r_y[CORDIC_STEPS-1];
        assign ux = fx[CW-1] ? CW'(-fx) : CW'(fx);
        assign uy = fy[CW-1] ? CW'(-fy) : CW'(fy);

        always_ff @(posedge i_clk) begin
            if (en) begin
                // flags: sign differs, overflow, zero sine, negative x
                r_pf[3] <= fx[CW-1] ^ fy[CW-1];
                r_pf[2] <= ({15'b0, ux} >= {uy, 15'b0});
                r_pf[1] <= (fy == '0);
                r_pf[0] <= fx[CW-1];
                r_pn    <= ({15'b0, ux} >= {uy, 15'b0}) ? '0 : {ux, 16'b0};
                r_pd    <= uy;
            end
        end

        cas3b_div #(.NW(CNW), .DW(CW), .QW(CQ)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_pn),
            .i_den (r_pd),
            .o_quo (quo)
        );

        cas3b_dly #(.W(4), .D(CQ)) u_dly (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (r_pf),
            .o_q   (pf_d)
        );

        assign lim = $signed({2'b00, i_cfg.cot_limit, 16'h0000});
        assign cv  = 33'(sat_q(pf_d[2], pf_d[3], quo));

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (pf_d[1]) begin
                    r_cot[l] <= 32'(pf_d[0] ? -lim : lim);
                end else if (cv > lim) begin
                    r_cot[l] <= 32'(lim);
                end else if (cv < -lim) begin
                    r_cot[l] <= 32'(-lim);
                end else begin
                    r_cot[l] <= 32'(cv);
                end
            end
        end
    end

    // ---------------- auxiliary points ----------------
    logic signed [16:0] d0, d1, d2, d3;
    logic signed [48:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [49:0] t0, t1, t2, t3;
    logic signed [HW-1:0] r_xh1, r_yh1, r_xh2, r_yh2;
    logic signed [HW-1:0] r_dx, r_dy, r_dxh1, r_dyh1;

    assign d0 = 17'(i_cfg.b3y) - 17'(i_cfg.b1y);
    assign d1 = 17'(i_cfg.b1x) - 17'(i_cfg.b3x);
    assign d2 = 17'(i_cfg.b2y) - 17'(i_cfg.b3y);
    assign d3 = 17'(i_cfg.b3x) - 17'(i_cfg.b2x);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0 <= d0 * r_cot[0];
            r_p1 <= d1 * r_cot[0];
            r_p2 <= d2 * r_cot[1];
            r_p3 <= d3 * r_cot[1];
        end
    end

    // round to whole mm, ties upward
    assign t0 = 50'(r_p0) + 50'sd32768;
    assign t1 = 50'(r_p1) + 50'sd32768;
    assign t2 = 50'(r_p2) + 50'sd32768;
    assign t3 = 50'(r_p3) + 50'sd32768;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xh1 <= HW'(i_cfg.b1x) + HW'(t0 >>> 16);
            r_yh1 <= HW'(i_cfg.b1y) + HW'(t1 >>> 16);
            r_xh2 <= HW'(i_cfg.b2x) + HW'(t2 >>> 16);
            r_yh2 <= HW'(i_cfg.b2y) + HW'(t3 >>> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx   <= r_xh2 - r_xh1;
            r_dy   <= r_yh2 - r_yh1;
            r_dxh1 <= r_xh1;
            r_dyh1 <= r_yh1;
        end
    end

    // ---------------- slope n and its inverse ----------------
    logic [HW-1:0]   udx, udy;
    logic            ovf_n, ovf_i;
    logic [SNW-1:0]  r_nn_num, r_ni_num;
    logic [HW-1:0]   r_udx, r_udy;
    logic [SB_W-1:0] r_sb, sb_d;
    logic [CQ-1:0]   quo_n, quo_i;
    logic signed [31:0] r_n, r_inv;
    logic signed [HW-1:0] r_fxh1, r_fyh1;
    logic            r_fdeg;

    assign udx   = r_dx[HW-1] ? HW'(-r_dx) : HW'(r_dx);
    assign udy   = r_dy[HW-1] ? HW'(-r_dy) : HW'(r_dy);
    assign ovf_n = ({15'b0, udx} >= {udy, 15'b0});
    assign ovf_i = ({15'b0, udy} >= {udx, 15'b0});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nn_num <= ovf_n ? '0 : {udx, 16'b0};
            r_ni_num <= ovf_i ? '0 : {udy, 16'b0};
            r_udx    <= udx;
            r_udy    <= udy;
            r_sb     <= {r_dx[HW-1] ^ r_dy[HW-1], ovf_n, ovf_i,
                         (r_dx == '0) || (r_dy == '0), r_dxh1, r_dyh1};
        end
    end

    cas3b_div #(.NW(SNW), .DW(HW), .QW(CQ)) u_div_n (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_nn_num),
        .i_den (r_udy),
        .o_quo (quo_n)
    );

    cas3b_div #(.NW(SNW), .DW(HW), .QW(CQ)) u_div_i (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_ni_num),
        .i_den (r_udx),
        .o_quo (quo_i)
    );

    cas3b_dly #(.W(SB_W), .D(CQ)) u_dly_s (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_sb),
        .o_q   (sb_d)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n    <= sat_q(sb_d[SB_W-2], sb_d[SB_W-1], quo_n);
            r_inv  <= sat_q(sb_d[SB_W-3], sb_d[SB_W-1], quo_i);
            r_fdeg <= sb_d[SB_W-4];
            r_fxh1 <= $signed(sb_d[2*HW-1:HW]);
            r_fyh1 <= $signed(sb_d[HW-1:0]);
        end
    end

    // ---------------- N = n + 1/n ----------------
    logic signed [32:0] nsum;
    logic signed [31:0] nsat;
    logic signed [31:0] r_nn, r_n2, r_inv2;
    logic signed [HW-1:0] r_nxh1, r_nyh1;
    logic            r_ndeg;

    assign nsum = 33'(r_n) + 33'(r_inv);
    assign nsat = (nsum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                  (nsum < -33'sh0_8000_0000) ? 32'sh8000_0000 : 32'(nsum);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nn   <= nsat;
            r_ndeg <= r_fdeg || (nsat == '0);
            r_n2   <= r_n;
            r_inv2 <= r_inv;
            r_nxh1 <= r_fxh1;
            r_nyh1 <= r_fyh1;
        end
    end

    // ---------------- position numerators ----------------
    logic signed [HW-1:0] ex, ey;
    logic signed [50:0] r_pxl, r_pyl;
    logic signed [49:0] r_pxh, r_pyh;
    logic signed [HW-1:0] r_ex, r_ey;
    logic signed [31:0] r_nn1, r_nn2;
    logic               r_deg1, r_deg2;
    logic signed [PNW-1:0] r_numx, r_numy;

    assign ex = r_nxh1 - HW'(i_cfg.b3x);
    assign ey = r_nyh1 - HW'(i_cfg.b3y);

    // 32 x 36 products split over two 32 x 18 halves
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxl  <= r_inv2 * $signed({1'b0, ex[17:0]});
            r_pxh  <= r_inv2 * $signed(ex[HW-1:18]);
            r_pyl  <= r_n2 * $signed({1'b0, ey[17:0]});
            r_pyh  <= r_n2 * $signed(ey[HW-1:18]);
            r_ex   <= ex;
            r_ey   <= ey;
            r_nn1  <= r_nn;
            r_deg1 <= r_ndeg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_numx <= (PNW'(r_pxh) <<< 18) + PNW'(r_pxl) - (PNW'(r_ey) <<< 16);
            r_numy <= (PNW'(r_pyh) <<< 18) + PNW'(r_pyl) - (PNW'(r_ex) <<< 16);
            r_nn2  <= r_nn1;
            r_deg2 <= r_deg1;
        end
    end

    // ---------------- position division ----------------
    logic [PNW-1:0]  magx, magy;
    logic [31:0]     unn;
    logic            povx, povy;
    logic [PNW-1:0]  r_pnx, r_pny;
    logic [31:0]     r_pden;
    logic [PB_W-1:0] r_pb, pb_d;
    logic [PQ-1:0]   quo_x, quo_y;
    t_out            r_out;

    assign magx = r_numx[PNW-1] ? PNW'(-r_numx) : PNW'(r_numx);
    assign magy = r_numy[PNW-1] ? PNW'(-r_numy) : PNW'(r_numy);
    assign unn  = r_nn2[31] ? 32'(-r_nn2) : 32'(r_nn2);
    assign povx = (magx >= PNW'({unn, 17'b0}));
    assign povy = (magy >= PNW'({unn, 17'b0}));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pnx  <= povx ? '0 : magx;
            r_pny  <= povy ? '0 : magy;
            r_pden <= unn;
            r_pb   <= {r_numx[PNW-1] ^ r_nn2[31], povx,
                       r_numy[PNW-1] ^ r_nn2[31], povy, r_deg2, r_nn2};
        end
    end

    cas3b_div #(.NW(PNW), .DW(32), .QW(PQ)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_pnx),
        .i_den (r_pden),
        .o_quo (quo_x)
    );

    cas3b_div #(.NW(PNW), .DW(32), .QW(PQ)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_pny),
        .i_den (r_pden),
        .o_quo (quo_y)
    );

    cas3b_dly #(.W(PB_W), .D(PQ)) u_dly_p (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_pb),
        .o_q   (pb_d)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (pb_d[QN_W]) begin
                r_out.pos_x      <= '0;
                r_out.pos_y      <= '0;
                r_out.quality_n  <= '0;
                r_out.degenerate <= 1'b1;
            end else begin
                r_out.pos_x      <= pos_calc(pb_d[QN_W+3], pb_d[QN_W+4], quo_x, i_cfg.b3x);
                r_out.pos_y      <= pos_calc(pb_d[QN_W+1], pb_d[QN_W+2], quo_y, i_cfg.b3y);
                r_out.quality_n  <= $signed(pb_d[QN_W-1:0]);
                r_out.degenerate <= 1'b0;
            end
        end
    end

    assign o_data = r_out;

endmodule

>>> design/cassini_three_beacon_position_core.sv
// Three-beacon position core: beacon registers, front stage, queue and arithmetic pipeline.
//
// Takes one bearing request per clock while the queue has room, and returns one result per
// request, in order. Results pass through R pi-reduction steps (3 at 16 fraction bits), the
// CORDIC stages and three ranks of restoring dividers (31, 31 and 17 stages). A held output
// stalls the pipeline and, once the four-entry queue fills, the input. Beacon
// registers must only be written while no request is in flight.
module cassini_three_beacon_position_core
    import cas3b_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out                  o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cls front_cls;
    t_cls q_cls;
    logic push;
    logic q_full;
    logic q_valid;
    logic take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.b1x       <= '0;
            r_cfg.b1y       <= '0;
            r_cfg.b2x       <= '0;
            r_cfg.b2y       <= '0;
            r_cfg.b3x       <= '0;
            r_cfg.b3y       <= '0;
            r_cfg.cot_limit <= '1;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_B1X:     r_cfg.b1x       <= $signed(i_cfg_data);
                REG_B1Y:     r_cfg.b1y       <= $signed(i_cfg_data);
                REG_B2X:     r_cfg.b2x       <= $signed(i_cfg_data);
                REG_B2Y:     r_cfg.b2y       <= $signed(i_cfg_data);
                REG_B3X:     r_cfg.b3x       <= $signed(i_cfg_data);
                REG_B3Y:     r_cfg.b3y       <= $signed(i_cfg_data);
                REG_COT_LIM: r_cfg.cot_limit <= i_cfg_data[LIM_W-1:0];
                default:     ;
            endcase
        end
    end

    cas3b_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cls    (front_cls)
    );

    cas3b_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (take),
        .o_data  (q_cls)
    );

    cas3b_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_cls   (q_cls),
        .o_take  (take),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

>>> design/cas3b_chk.sv
// Port-level checks for the three-beacon position core, bound to the top level.
module cas3b_chk
    import cas3b_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input t_in                   i_data,
    input logic                  o_valid,
    input logic                  i_ready,
    input t_out                  o_data,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // a stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |->
            o_data.pos_x == '0 && o_data.pos_y == '0 && o_data.quality_n == '0)
        else $error("degenerate result carries nonzero fields");

    a_n_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.degenerate |-> o_data.quality_n != '0)
        else $error("zero N without degenerate flag");

    a_rst_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) && $past(i_rst_n, 2) == 1'b0 |-> !o_valid)
        else $error("result valid straight after reset");

endmodule

bind cassini_three_beacon_position_core cas3b_chk u_chk (.*);
